[rtl/core/lphm_pkg.sv]
// Shared constants and types for the linear-probing hash map.
`default_nettype none
package lphm_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int KEY_BITS    = 20;
   localparam int VALUE_BITS  = 20;

   localparam int IDX_W   = $clog2(TABLE_DEPTH);
   localparam int KV_W    = KEY_BITS + VALUE_BITS;
   localparam bit IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;

   // key / TABLE_DEPTH == (key * RECIP) >> REM_SHIFT for every key below 2**KEY_BITS
   localparam int     REM_SHIFT = KEY_BITS + IDX_W;
   localparam longint RECIP     = ((longint'(1) << REM_SHIFT) + longint'(TABLE_DEPTH) - 1)
                                  / longint'(TABLE_DEPTH);

   typedef enum logic [1:0] {
      FUNC_PUT    = 2'd0,
      FUNC_GET    = 2'd1,
      FUNC_REMOVE = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      SLOT_EMPTY   = 2'd0,
      SLOT_USED    = 2'd1,
      SLOT_DELETED = 2'd2
   } slot_state_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_PROBE
   } hmap_state_type;

   typedef struct packed {
      func_type                func;
      logic [KEY_BITS-1:0]     key;
      logic [VALUE_BITS-1:0]   put_value;
   } req_type;

   typedef struct packed {
      logic                    hit;
      logic [VALUE_BITS-1:0]   read_value;
      logic                    table_full;
   } rsp_type;

endpackage
`default_nettype wire

[rtl/core/lphm_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none
module lphm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[rtl/core/linear_probe_hash_map_top.sv]
// Linear-probing hash map: control FSM around slot-state and key/value RAMs.
`default_nettype none
// Open-addressing key/value table. Raise start with an item on req_item while busy
// is low; the item is taken at that edge. The block then walks the probe path one
// slot per cycle (one RAM read per cycle from the slot-state and key/value RAMs),
// so an operation keeps busy high while it examines from 1 up to TABLE_DEPTH slots,
// and also through two reciprocal-multiply home-slot reduction steps when
// TABLE_DEPTH is not a power of two. The result is shown on rsp_item for exactly
// one cycle with rsp_valid high, the cycle after the last slot is examined, and the
// next start may be taken in that same cycle. The receiver cannot stall: it must
// take every result in its strobe cycle. An item with an undefined func is answered
// with an all-zero result in the cycle after it is taken. After reset the block
// clears every slot of the slot-state RAM with busy high.
module linear_probe_hash_map_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire lphm_pkg::req_type req_item,
   output logic                  rsp_valid,
   output lphm_pkg::rsp_type     rsp_item
);
   import lphm_pkg::*;

   localparam logic [IDX_W-1:0]  LAST_SLOT  = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [KEY_BITS:0] RECIP_C    = (KEY_BITS + 1)'(RECIP);

   hmap_state_type          state_ff, state_in;
   func_type                func_ff, func_in;
   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [VALUE_BITS-1:0]   value_ff, value_in;
   logic [KEY_BITS-1:0]     quot_ff, quot_in;
   logic                    phase_ff, phase_in;
   logic [IDX_W-1:0]        pos_ff, pos_in;
   logic [IDX_W-1:0]        cnt_ff, cnt_in;
   logic                    free_valid_ff, free_valid_in;
   logic [IDX_W-1:0]        free_pos_ff, free_pos_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   // RAM ports
   logic                    stat_we;
   logic [IDX_W-1:0]        stat_waddr;
   logic [1:0]              stat_wdata;
   logic [1:0]              stat_rdata;
   logic                    kv_we;
   logic [IDX_W-1:0]        kv_waddr;
   logic [KV_W-1:0]         kv_wdata;
   logic [KV_W-1:0]         kv_rdata;
   logic [IDX_W-1:0]        rd_addr;

   // probe evaluation
   slot_state_type          slot_st;
   logic                    is_empty;
   logic                    is_used;
   logic                    key_match;
   logic                    free_now_valid;
   logic [IDX_W-1:0]        free_now_pos;
   logic [IDX_W-1:0]        pos_next;
   logic                    probe_done;
   logic [2*KEY_BITS:0]     quot_prod;
   logic [KEY_BITS-1:0]     quot_now;
   logic [IDX_W-1:0]        home_pos;
   logic                    func_ok;

   lphm_ram #(.WIDTH(2), .DEPTH(TABLE_DEPTH)) u_stat_ram (
      .clock   (clock),
      .wr_en   (stat_we),
      .wr_addr (stat_waddr),
      .wr_data (stat_wdata),
      .rd_addr (rd_addr),
      .rd_data (stat_rdata)
   );

   lphm_ram #(.WIDTH(KV_W), .DEPTH(TABLE_DEPTH)) u_kv_ram (
      .clock   (clock),
      .wr_en   (kv_we),
      .wr_addr (kv_waddr),
      .wr_data (kv_wdata),
      .rd_addr (rd_addr),
      .rd_data (kv_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      quot_ff       <= quot_in;
      phase_ff      <= phase_in;
      pos_ff        <= pos_in;
      free_valid_ff <= free_valid_in;
      free_pos_ff   <= free_pos_in;
      rsp_ff        <= rsp_in;
   end

   always_comb begin
      slot_st        = slot_state_type'(stat_rdata);
      is_empty       = slot_st == SLOT_EMPTY;
      is_used        = slot_st == SLOT_USED;
      key_match      = is_used && (kv_rdata[KV_W-1:VALUE_BITS] == key_ff);
      // empty and deleted slots both count as free
      free_now_valid = free_valid_ff || !is_used;
      free_now_pos   = free_valid_ff ? free_pos_ff : pos_ff;
      pos_next       = (pos_ff == LAST_SLOT) ? '0 : pos_ff + IDX_W'(1);
      probe_done     = is_empty || key_match || (cnt_ff == LAST_SLOT);
      quot_prod      = (2 * KEY_BITS + 1)'(key_ff) * (2 * KEY_BITS + 1)'(RECIP_C);
      quot_now       = KEY_BITS'(quot_prod >> REM_SHIFT);
      home_pos       = IDX_W'(key_ff - KEY_BITS'(quot_ff * KEY_BITS'(TABLE_DEPTH)));
      func_ok        = (req_item.func == FUNC_PUT) || (req_item.func == FUNC_GET) ||
                       (req_item.func == FUNC_REMOVE);
   end

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      quot_in       = quot_ff;
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      cnt_in        = cnt_ff;
      free_valid_in = free_valid_ff;
      free_pos_in   = free_pos_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      rd_addr       = pos_ff;
      stat_we       = 1'b0;
      stat_waddr    = pos_ff;
      stat_wdata    = SLOT_EMPTY;
      kv_we         = 1'b0;
      kv_waddr      = pos_ff;
      kv_wdata      = {key_ff, value_ff};
      busy          = state_ff != ST_IDLE;

      unique case (state_ff)
         ST_CLEAR: begin
            stat_we    = 1'b1;
            stat_waddr = cnt_ff;
            stat_wdata = SLOT_EMPTY;
            cnt_in     = cnt_ff + IDX_W'(1);
            if (cnt_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
               cnt_in   = '0;
            end
         end
         ST_IDLE: begin
            if (start) begin
               func_in       = req_item.func;
               key_in        = req_item.key;
               value_in      = req_item.put_value;
               cnt_in        = '0;
               free_valid_in = 1'b0;
               if (!func_ok) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
               end else if (IS_POW2) begin
                  pos_in   = IDX_W'(req_item.key);
                  rd_addr  = IDX_W'(req_item.key);
                  state_in = ST_PROBE;
               end else begin
                  phase_in = 1'b0;
                  state_in = ST_HASH;
               end
            end
         end
         ST_HASH: begin
            // first step: quotient by reciprocal; second step: key minus quotient times depth
            phase_in = 1'b1;
            if (!phase_ff) begin
               quot_in = quot_now;
            end else begin
               pos_in   = home_pos;
               rd_addr  = home_pos;
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            // next slot is read speculatively; unused if this one ends the walk
            rd_addr = pos_next;
            if (probe_done) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               rsp_in.hit   = key_match;
               case (func_ff)
                  FUNC_PUT: begin
                     if (key_match) begin
                        kv_we    = 1'b1;
                        kv_waddr = pos_ff;
                     end else if (free_now_valid) begin
                        kv_we      = 1'b1;
                        kv_waddr   = free_now_pos;
                        stat_we    = 1'b1;
                        stat_waddr = free_now_pos;
                        stat_wdata = SLOT_USED;
                     end else begin
                        rsp_in.table_full = 1'b1;
                     end
                  end
                  FUNC_GET: begin
                     if (key_match) begin
                        rsp_in.read_value = kv_rdata[VALUE_BITS-1:0];
                     end
                  end
                  FUNC_REMOVE: begin
                     if (key_match) begin
                        stat_we    = 1'b1;
                        stat_waddr = pos_ff;
                        stat_wdata = SLOT_DELETED;
                     end
                  end
                  default: begin
                     rsp_in = '0;
                  end
               endcase
            end else begin
               pos_in        = pos_next;
               cnt_in        = cnt_ff + IDX_W'(1);
               free_valid_in = free_now_valid;
               free_pos_in   = free_now_pos;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            cnt_in   = '0;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef SYNTH
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_PROBE || (state_ff == ST_IDLE && start)))
      else $error("result strobe without a finished walk or undefined func");

   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.table_full |-> !rsp_item.hit && rsp_item.read_value == '0)
      else $error("table_full result carries hit or data");

   a_value_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.read_value != '0 |-> rsp_item.hit)
      else $error("read_value without hit");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PROBE && cnt_ff == LAST_SLOT |=> state_ff == ST_IDLE && rsp_valid)
      else $error("probe walk ran past table depth");

   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> busy && !rsp_valid)
      else $error("activity during clearing pass");
`endif

endmodule
`default_nettype wire
